// ===== hdl/msu_pkg.sv =====
// shared types and constants of the multi timer service unit
// no dependencies; imported by every module of the block

package msu_pkg;

	// default bank size and fixed limits
	localparam int TIMER_COUNT_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int RCNT_W          = 5;
	localparam int IDX_EXT_W       = 7;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = 1;
	localparam logic [31:0] PERIOD_ONE = 32'd1;

	// command codes on the input beat
	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_START      = 3'd1,
		OP_STOP       = 3'd2,
		OP_SET_PERIOD = 3'd3,
		OP_SET_MODE   = 3'd4,
		OP_QUERY      = 3'd5
	} op_t;

	// result codes
	typedef enum logic [1:0] {
		KIND_EXPIRY = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CMD_RD,
		BK_CMD_EXEC,
		BK_TICK,
		BK_DRAIN,
		BK_FLUSH
	} bk_state_t;

	// classified job handed from front to back
	typedef struct packed {
		op_t                    op;
		logic [3:0]             index;
		logic [IDX_EXT_W-1:0]   addr;
		logic                   idx_ok;
		logic [31:0]            payload;  // tick delta or clamped period
		logic                   one_shot;
		logic                   notify;
	} job_t;

	// one result beat
	typedef struct packed {
		logic        strobe;
		kind_t       kind;
		logic [3:0]  which;
		logic [31:0] elapsed;
		logic        running;
		logic [31:0] period;
		logic        mode;
		logic        last;
	} res_t;

endpackage

// ===== hdl/multi_timer_service_unit.sv =====
// top level of the multi timer service unit
// depends on msu_pkg, msu_front and msu_back

// A command beat is taken when start is high and busy is low; busy rises only
// while the two-entry job queue is full. Results come as one-cycle strobes and
// cannot be held off. A command passes in the back end through queue pop,
// period memory read and execute, and gives one result with last set. On a
// tick the back end walks the accumulator and period memories one timer per
// cycle through their single read port, then drains and flushes the final
// expiry, which carries last. The first tick after reset and opcodes six and
// seven are absorbed in the front end in the accept cycle and give no result;
// a tick without reported expiry gives none either.

module multi_timer_service_unit import msu_pkg::*; #(
	parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  timer_index,
	input  logic [31:0] time_ms,
	input  logic [31:0] period_ms,
	input  logic        one_shot,
	input  logic        notify,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [3:0]  which_timer,
	output logic [31:0] elapsed_ms,
	output logic        is_running,
	output logic [31:0] period_out,
	output logic        mode_out,
	output logic        last
);

	logic q_valid;
	logic q_pop;
	job_t q_data;
	res_t res;

	msu_front #(.TIMER_COUNT(TIMER_COUNT)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.timer_index (timer_index),
		.time_ms     (time_ms),
		.period_ms   (period_ms),
		.one_shot    (one_shot),
		.notify      (notify),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop)
	);

	msu_back #(.TIMER_COUNT(TIMER_COUNT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.res     (res)
	);

	// result beat onto the ports
	assign strobe      = res.strobe;
	assign kind        = res.kind;
	assign which_timer = res.which;
	assign elapsed_ms  = res.elapsed;
	assign is_running  = res.running;
	assign period_out  = res.period;
	assign mode_out    = res.mode;
	assign last        = res.last;

endmodule

// ===== hdl/msu_front.sv =====
// front end: accepts beats, tracks tick time, classifies and queues jobs
// depends on msu_pkg

module msu_front import msu_pkg::*; #(
	parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [3:0]  timer_index,
	input  logic [31:0] time_ms,
	input  logic [31:0] period_ms,
	input  logic        one_shot,
	input  logic        notify,
	output logic        q_valid,
	output job_t        q_data,
	input  logic        q_pop
);

	logic                started_q;
	logic [31:0]         prev_time_q;
	job_t                fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QPTR_W:0]     count_q;
	logic                accept;
	logic                push;
	job_t                push_data;
	logic [IDX_EXT_W-1:0] idx_ext;

	assign busy    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign accept  = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_data  = fifo_q[rptr_q];
	assign idx_ext = IDX_EXT_W'(timer_index);

	// classify the accepted beat
	always_comb begin
		push_data.op       = op_t'(opcode);
		push_data.index    = timer_index;
		push_data.addr     = idx_ext;
		push_data.idx_ok   = (idx_ext < IDX_EXT_W'(TIMER_COUNT));
		push_data.one_shot = one_shot;
		push_data.notify   = notify;
		push_data.payload  = (period_ms == '0) ? PERIOD_ONE : period_ms;
		push = 1'b0;
		case (opcode)
			OP_TICK: begin
				push_data.payload = time_ms - prev_time_q;
				push = accept && started_q;
			end
			OP_START, OP_STOP, OP_SET_PERIOD, OP_SET_MODE, OP_QUERY: begin
				push = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// tick time tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			prev_time_q <= '0;
		end else if (accept && opcode == OP_TICK) begin
			started_q   <= 1'b1;
			prev_time_q <= time_ms;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (q_pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(q_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= push_data;
	end

endmodule

// ===== hdl/msu_back.sv =====
// back end: executes commands and walks the timer bank on each tick
// depends on msu_pkg; holds the accumulator and period memories

module msu_back import msu_pkg::*; #(
	parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  job_t q_data,
	output logic q_pop,
	output res_t res
);

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	bk_state_t state_q, state_d;
	job_t      job_q;
	logic [IW-1:0] walk_q;
	logic [IW-1:0] rd_addr;
	logic          walk_end;

	// memories
	logic [31:0] acc_mem [TIMER_COUNT];
	logic [31:0] per_mem [TIMER_COUNT];
	logic [31:0] acc_rd_s1;
	logic [31:0] per_rd_s1;
	logic        v_s1;
	logic [IW-1:0] idx_s1;

	// per timer flags
	logic [TIMER_COUNT-1:0] running_q;
	logic [TIMER_COUNT-1:0] oneshot_q;
	logic [TIMER_COUNT-1:0] notify_q;
	logic [TIMER_COUNT-1:0] per_valid_q;

	// write ports
	logic          acc_we;
	logic [IW-1:0] acc_wa;
	logic [31:0]   acc_wd;
	logic          per_we;

	// tick walk datapath
	logic [32:0] sum1;
	logic [31:0] accn1;
	logic [31:0] per1;
	logic        run1;
	logic        exp1;
	logic        report1;
	res_t        exp_res;

	// command datapath
	logic [IW-1:0] t_cmd;
	logic          cur_run;
	logic [31:0]   cur_per;
	logic          cur_mode;
	res_t          cmd_res;

	// reporting
	res_t             pend_q;
	logic             pend_v_q;
	logic [RCNT_W-1:0] n_q;
	res_t             res_q;
	res_t             res_d;

	assign res      = res_q;
	assign walk_end = (walk_q == IW'(TIMER_COUNT - 1));
	assign t_cmd    = job_q.addr[IW-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer controls
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_addr = t_cmd;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_data.op == OP_TICK) ? BK_TICK : BK_CMD_RD;
				end
			end
			BK_CMD_RD:   state_d = BK_CMD_EXEC;
			BK_CMD_EXEC: state_d = BK_IDLE;
			BK_TICK: begin
				rd_addr = walk_q;
				if (walk_end) state_d = BK_DRAIN;
			end
			BK_DRAIN: state_d = BK_FLUSH;
			BK_FLUSH: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// job register and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= (state_q == BK_TICK);
			if (state_q == BK_TICK) walk_q <= walk_end ? '0 : walk_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_data;
		idx_s1 <= walk_q;
	end

	// memory read, registered
	always_ff @(posedge clk) begin
		acc_rd_s1 <= acc_mem[rd_addr];
		per_rd_s1 <= per_mem[rd_addr];
	end

	// memory write
	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
		if (per_we) per_mem[t_cmd] <= job_q.payload;
	end

	// saturating accumulate and expiry check for the walked timer
	always_comb begin
		run1    = running_q[idx_s1];
		per1    = per_valid_q[idx_s1] ? per_rd_s1 : PERIOD_ONE;
		sum1    = {1'b0, acc_rd_s1} + {1'b0, job_q.payload};
		accn1   = sum1[32] ? '1 : sum1[31:0];
		exp1    = v_s1 && run1 && (accn1 >= per1);
		report1 = exp1 && notify_q[idx_s1] && (n_q < RCNT_W'(MAX_RESULTS));
		exp_res.strobe  = 1'b1;
		exp_res.kind    = KIND_EXPIRY;
		exp_res.which   = 4'(idx_s1);
		exp_res.elapsed = accn1;
		exp_res.running = !oneshot_q[idx_s1];
		exp_res.period  = per1;
		exp_res.mode    = oneshot_q[idx_s1];
		exp_res.last    = 1'b0;
	end

	// command result as seen after the operation
	always_comb begin
		cur_run  = running_q[t_cmd];
		cur_per  = per_valid_q[t_cmd] ? per_rd_s1 : PERIOD_ONE;
		cur_mode = oneshot_q[t_cmd];
		cmd_res.strobe  = 1'b1;
		cmd_res.kind    = (job_q.op == OP_QUERY) ? KIND_QUERY : KIND_ACK;
		cmd_res.which   = job_q.index;
		cmd_res.elapsed = '0;
		cmd_res.running = cur_run;
		cmd_res.period  = cur_per;
		cmd_res.mode    = cur_mode;
		cmd_res.last    = 1'b1;
		case (job_q.op)
			OP_START:      cmd_res.running = 1'b1;
			OP_STOP:       cmd_res.running = 1'b0;
			OP_SET_PERIOD: cmd_res.period  = job_q.payload;
			OP_SET_MODE:   cmd_res.mode    = job_q.one_shot;
			default:       cmd_res.kind    = cmd_res.kind;
		endcase
		if (!job_q.idx_ok) begin
			cmd_res.running = 1'b0;
			cmd_res.period  = PERIOD_ONE;
			cmd_res.mode    = 1'b0;
		end
	end

	// accumulator and period write selection
	always_comb begin
		acc_we = 1'b0;
		acc_wa = idx_s1;
		acc_wd = exp1 ? '0 : accn1;
		per_we = 1'b0;
		if (v_s1 && run1) begin
			acc_we = 1'b1;
		end else if (state_q == BK_CMD_EXEC && job_q.idx_ok) begin
			acc_wa = t_cmd;
			acc_wd = '0;
			acc_we = (job_q.op == OP_START && !cur_run) ||
				(job_q.op == OP_SET_PERIOD && cur_run);
			per_we = (job_q.op == OP_SET_PERIOD);
		end
	end

	// timer flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			oneshot_q   <= '0;
			notify_q    <= '0;
			per_valid_q <= '0;
		end else begin
			if (exp1 && oneshot_q[idx_s1]) running_q[idx_s1] <= 1'b0;
			if (state_q == BK_CMD_EXEC && job_q.idx_ok) begin
				case (job_q.op)
					OP_START:      running_q[t_cmd] <= 1'b1;
					OP_STOP:       running_q[t_cmd] <= 1'b0;
					OP_SET_PERIOD: per_valid_q[t_cmd] <= 1'b1;
					OP_SET_MODE: begin
						oneshot_q[t_cmd] <= job_q.one_shot;
						notify_q[t_cmd]  <= job_q.notify;
					end
					default: running_q <= running_q;
				endcase
			end
		end
	end

	// next result beat: command result, a displaced expiry or the final expiry
	always_comb begin
		res_d        = res_q;
		res_d.strobe = 1'b0;
		if (state_q == BK_CMD_EXEC) res_d = cmd_res;
		if (report1 && pend_v_q) res_d = pend_q;
		if (state_q == BK_FLUSH && pend_v_q) begin
			res_d      = pend_q;
			res_d.last = 1'b1;
		end
	end

	// result beats: expiries wait in a pending slot until the next one or the walk end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			n_q      <= '0;
		end else begin
			res_q <= res_d;
			if (report1) begin
				pend_q   <= exp_res;
				pend_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
			end else if (state_q == BK_FLUSH) begin
				pend_v_q <= 1'b0;
				n_q      <= '0;
			end
		end
	end

endmodule

// ===== hdl/msu_checker.sv =====
// port level checks of the multi timer service unit, bound to the top level
// depends on msu_pkg and multi_timer_service_unit

module msu_checker import msu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        strobe,
	input logic [1:0]  kind,
	input logic [31:0] elapsed_ms,
	input logic        is_running,
	input logic [31:0] period_out,
	input logic        mode_out,
	input logic        last
);

	// acknowledge and query are single beats
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != KIND_EXPIRY |-> last)
		else $error("command result without last");

	// only expiries carry elapsed time
	a_cmd_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != KIND_EXPIRY |-> elapsed_ms == 32'd0)
		else $error("command result with elapsed time");

	// an expiry has reached its period
	a_exp_reached: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_EXPIRY |-> elapsed_ms >= period_out && period_out != 32'd0)
		else $error("expiry below its period");

	// periodic timers keep running, one-shot timers stop
	a_exp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_EXPIRY |-> is_running == !mode_out)
		else $error("expiry running flag does not match mode");

endmodule

bind multi_timer_service_unit msu_checker u_msu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.strobe     (strobe),
	.kind       (kind),
	.elapsed_ms (elapsed_ms),
	.is_running (is_running),
	.period_out (period_out),
	.mode_out   (mode_out),
	.last       (last)
);
